// ===== src/mmu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the matrix multiply unit.
package mmu_pkg;

    localparam int MAX_DIM    = 8;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int VAL_W      = 32;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int ACC_W      = PROD_W + IDX_W;
    localparam int FRAC_W     = 16;
    localparam int DIM_W      = 4;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_COMPUTE
    } cmd_kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [VAL_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] m_last;
        logic [IDX_W-1:0] n_last;
        logic [IDX_W-1:0] p_last;
    } dims_t;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             lastk;
        logic             last;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } tag_t;

    // Last valid index for a dimension register; the dimension is clamped to 1..MAX_DIM.
    function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] d);
        logic [IDX_W-1:0] r;
        if (d == '0) begin
            r = '0;
        end else if (d > DIM_W'(MAX_DIM)) begin
            r = IDX_W'(MAX_DIM - 1);
        end else begin
            r = IDX_W'(d - 1'b1);
        end
        return r;
    endfunction

endpackage

// ===== src/mmu_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, input acceptance and command classification.
module mmu_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mmu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mmu_pkg::DIM_W-1:0]        cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mmu_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [mmu_pkg::OP_W-1:0]         s_tuser,
    input  logic                             fifo_full,
    output logic                             push,
    output mmu_pkg::cmd_t                    push_cmd,
    output mmu_pkg::dims_t                   dims
);

    logic [mmu_pkg::DIM_W-1:0] rows_a_reg;
    logic [mmu_pkg::DIM_W-1:0] inner_dim_reg;
    logic [mmu_pkg::DIM_W-1:0] cols_b_reg;
    mmu_pkg::op_t              op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg    <= mmu_pkg::DIM_W'(4);
            inner_dim_reg <= mmu_pkg::DIM_W'(4);
            cols_b_reg    <= mmu_pkg::DIM_W'(4);
        end else if (cfg_wr_en) begin
            unique case (mmu_pkg::cfg_reg_t'(cfg_index))
                mmu_pkg::REG_ROWS_A:    rows_a_reg    <= cfg_wdata;
                mmu_pkg::REG_INNER_DIM: inner_dim_reg <= cfg_wdata;
                mmu_pkg::REG_COLS_B:    cols_b_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign dims.m_last = mmu_pkg::dim_last(rows_a_reg);
    assign dims.n_last = mmu_pkg::dim_last(inner_dim_reg);
    assign dims.p_last = mmu_pkg::dim_last(cols_b_reg);

    assign s_tready = !fifo_full;
    assign op       = mmu_pkg::op_t'(s_tuser);

    always_comb begin
        push_cmd.row   = s_tdata[mmu_pkg::IDX_W-1:0];
        push_cmd.col   = s_tdata[2*mmu_pkg::IDX_W-1:mmu_pkg::IDX_W];
        push_cmd.value = s_tdata[2*mmu_pkg::IDX_W+mmu_pkg::VAL_W-1:2*mmu_pkg::IDX_W];
        push_cmd.kind  = mmu_pkg::CMD_COMPUTE;
        push           = 1'b0;
        unique case (op)
            mmu_pkg::OP_WRITE_A: begin
                push_cmd.kind = mmu_pkg::CMD_LOAD_A;
                push          = s_tvalid && s_tready;
            end
            mmu_pkg::OP_WRITE_B: begin
                push_cmd.kind = mmu_pkg::CMD_LOAD_B;
                push          = s_tvalid && s_tready;
            end
            mmu_pkg::OP_COMPUTE: begin
                push_cmd.kind = mmu_pkg::CMD_COMPUTE;
                push          = s_tvalid && s_tready;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/mmu_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
module mmu_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mmu_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output mmu_pkg::cmd_t head
);

    mmu_pkg::cmd_t                   entries [mmu_pkg::FIFO_DEPTH];
    logic [mmu_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [mmu_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [mmu_pkg::FIFO_PTR_W:0]    count_reg;
    logic [mmu_pkg::FIFO_PTR_W:0]    count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full      = count_reg == (mmu_pkg::FIFO_PTR_W+1)'(mmu_pkg::FIFO_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = entries[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/mmu_back.sv =====
`timescale 1ns / 1ps
// Back end: matrix stores, multiply-accumulate pipeline and result register.
module mmu_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mmu_pkg::dims_t                    dims,
    input  logic                              cmd_valid,
    input  mmu_pkg::cmd_t                     cmd,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mmu_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam int SHIFT_W = mmu_pkg::ACC_W - mmu_pkg::FRAC_W;

    logic [mmu_pkg::VAL_W-1:0] mem_a [mmu_pkg::MAX_DIM*mmu_pkg::MAX_DIM];
    logic [mmu_pkg::VAL_W-1:0] mem_b [mmu_pkg::MAX_DIM*mmu_pkg::MAX_DIM];

    mmu_pkg::back_state_t         state_reg, state_next;
    logic [mmu_pkg::IDX_W-1:0]    i_reg, i_next;
    logic [mmu_pkg::IDX_W-1:0]    j_reg, j_next;
    logic [mmu_pkg::IDX_W-1:0]    k_reg, k_next;
    logic                         advance;
    logic                         wr_a;
    logic                         wr_b;
    mmu_pkg::tag_t                issue_tag;
    mmu_pkg::tag_t                s1_reg;
    mmu_pkg::tag_t                s2_reg;
    logic [mmu_pkg::ADDR_W-1:0]   a_addr;
    logic [mmu_pkg::ADDR_W-1:0]   b_addr;
    logic [mmu_pkg::ADDR_W-1:0]   w_addr;
    logic signed [mmu_pkg::VAL_W-1:0]  rd_a_reg;
    logic signed [mmu_pkg::VAL_W-1:0]  rd_b_reg;
    logic signed [mmu_pkg::PROD_W-1:0] prod_reg;
    logic signed [mmu_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mmu_pkg::ACC_W-1:0]  acc_next;
    logic signed [SHIFT_W-1:0]         shifted;
    logic [mmu_pkg::VAL_W-1:0]         sat_value;
    logic                              sat_flag;
    logic                              out_valid_reg;
    logic [mmu_pkg::IDX_W-1:0]         out_row_reg;
    logic [mmu_pkg::IDX_W-1:0]         out_col_reg;
    logic [mmu_pkg::VAL_W-1:0]         out_value_reg;
    logic                              out_sat_reg;
    logic                              out_last_reg;

    assign advance = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mmu_pkg::BK_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        pop             = 1'b0;
        wr_a            = 1'b0;
        wr_b            = 1'b0;
        issue_tag.valid = 1'b0;
        issue_tag.first = k_reg == '0;
        issue_tag.lastk = k_reg == dims.n_last;
        issue_tag.last  = (k_reg == dims.n_last) && (j_reg == dims.p_last)
                          && (i_reg == dims.m_last);
        issue_tag.i     = i_reg;
        issue_tag.j     = j_reg;
        unique case (state_reg)
            mmu_pkg::BK_IDLE: begin
                if (cmd_valid) begin
                    pop = 1'b1;
                    unique case (cmd.kind)
                        mmu_pkg::CMD_LOAD_A: wr_a = 1'b1;
                        mmu_pkg::CMD_LOAD_B: wr_b = 1'b1;
                        mmu_pkg::CMD_COMPUTE: begin
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            state_next = mmu_pkg::BK_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            mmu_pkg::BK_RUN: begin
                issue_tag.valid = 1'b1;
                if (advance) begin
                    if (k_reg != dims.n_last) begin
                        k_next = k_reg + 1'b1;
                    end else begin
                        k_next = '0;
                        if (j_reg != dims.p_last) begin
                            j_next = j_reg + 1'b1;
                        end else begin
                            j_next = '0;
                            if (i_reg != dims.m_last) begin
                                i_next = i_reg + 1'b1;
                            end else begin
                                state_next = mmu_pkg::BK_IDLE;
                            end
                        end
                    end
                end
            end
            default: state_next = mmu_pkg::BK_IDLE;
        endcase
    end

    assign a_addr = {i_reg, k_reg};
    assign b_addr = {k_reg, j_reg};
    assign w_addr = {cmd.row, cmd.col};

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            mem_a[w_addr] <= cmd.value;
        end
        if (advance) begin
            rd_a_reg <= mem_a[a_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_b) begin
            mem_b[w_addr] <= cmd.value;
        end
        if (advance) begin
            rd_b_reg <= mem_b[b_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
            s2_reg <= '0;
        end else if (advance) begin
            s1_reg <= issue_tag;
            s2_reg <= s1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= rd_a_reg * rd_b_reg;
        end
    end

    assign acc_next = (s2_reg.first ? '0 : acc_reg) + mmu_pkg::ACC_W'(prod_reg);
    assign shifted  = SHIFT_W'(acc_next >>> mmu_pkg::FRAC_W);

    always_comb begin
        sat_flag  = 1'b0;
        sat_value = shifted[mmu_pkg::VAL_W-1:0];
        if (shifted > SHIFT_W'(32'sh7FFF_FFFF)) begin
            sat_flag  = 1'b1;
            sat_value = 32'h7FFF_FFFF;
        end else if (shifted < -SHIFT_W'(64'sh8000_0000)) begin
            sat_flag  = 1'b1;
            sat_value = 32'h8000_0000;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s2_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && s2_reg.valid && s2_reg.lastk) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s2_reg.valid && s2_reg.lastk) begin
            out_row_reg   <= s2_reg.i;
            out_col_reg   <= s2_reg.j;
            out_value_reg <= sat_value;
            out_sat_reg   <= sat_flag;
            out_last_reg  <= s2_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = mmu_pkg::OUT_DATA_W'({out_value_reg, out_col_reg, out_row_reg});
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_hold_counters: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mmu_pkg::BK_RUN && !advance)
        |=> ($stable(i_reg) && $stable(j_reg) && $stable(k_reg)))
        else $error("issue counters moved during an output stall");

    a_last_ends_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_reg.valid && s2_reg.last) |-> s2_reg.lastk)
        else $error("final result flagged before its inner sum is complete");

    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (cmd_valid && state_reg == mmu_pkg::BK_IDLE))
        else $error("command taken while busy or queue empty");

    a_last_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_last_reg)
        |-> (out_row_reg == dims.m_last && out_col_reg == dims.p_last))
        else $error("final result is not the bottom-right entry");
`endif

endmodule

// ===== src/matrix_multiply_unit.sv =====
`timescale 1ns / 1ps
// A load item is written into its matrix store in the cycle it leaves the queue.
// A compute item moves the back end from idle to run, then issues rows*cols*inner MAC steps
// through the single multiplier; each entry passes the operand read, product and output registers.
// Throughput is set by that multiplier: one product per cycle when the output is taken.
// Reset (aresetn low, synchronous) empties the queue and pipeline, sets all dimensions to 4.
module matrix_multiply_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mmu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mmu_pkg::DIM_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // row [2:0], col [5:3], value [37:6], zero fill [39:38]
    input  logic [mmu_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation [1:0]
    input  logic [mmu_pkg::OP_W-1:0]          s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // res_row [2:0], res_col [5:3], res_value [37:6], zero fill [39:38]
    output logic [mmu_pkg::OUT_DATA_W-1:0]    m_tdata,
    // saturated [0]
    output logic                              m_tuser,
    output logic                              m_tlast
);

    logic           fifo_full;
    logic           push;
    mmu_pkg::cmd_t  push_cmd;
    mmu_pkg::dims_t dims;
    logic           pop;
    logic           cmd_valid;
    mmu_pkg::cmd_t  head;

    mmu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .push      (push),
        .push_cmd  (push_cmd),
        .dims      (dims)
    );

    mmu_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (fifo_full),
        .pop       (pop),
        .not_empty (cmd_valid),
        .head      (head)
    );

    mmu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dims      (dims),
        .cmd_valid (cmd_valid),
        .cmd       (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
